/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, removed when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_SYNC(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error(msg);

`define ASSERT_NEVER(lbl, clk_s, rst_s, expr, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(expr)) \
    else $error(msg);

`else

`define ASSERT_SYNC(lbl, clk_s, rst_s, prop, msg)

`define ASSERT_NEVER(lbl, clk_s, rst_s, expr, msg)

`endif

`endif

/* hdl/tbr_pkg.sv */
// ----------------------------------------------------------------------------
// Table reader package
// Field widths, default sizes, payload types and control structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tbr_pkg;

  localparam int DEF_NUM_FRAMES  = 16;
  localparam int DEF_NUM_POINTS  = 256;
  localparam int DEF_NUM_WORDS   = 4096;
  localparam int DEF_SLICE_WORDS = 16;

  localparam int FRAME_W = 8;
  localparam int POINT_W = 14;
  localparam int WADDR_W = 12;
  localparam int WORD_W  = 16;
  localparam int PASS_W  = 7;
  localparam int FLAT_W  = 22;
  localparam int IDX_W   = 17;

  localparam int HASH_MULT = 31;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic [FRAME_W-1:0]       frame_sel;
    logic [POINT_W-1:0]       point_sel;
    logic [WADDR_W-1:0]       wr_addr;
    logic signed [WORD_W-1:0] wr_data;
  } item_t;

  typedef struct packed {
    logic [FRAME_W-1:0]       echo_frame;
    logic [POINT_W-1:0]       echo_point;
    logic signed [WORD_W-1:0] read_value;
    logic [WORD_W-1:0]        latched_sum;
    logic [PASS_W-1:0]        pass_count;
  } result_t;

  typedef struct packed {
    logic load_item;
    logic do_write;
    logic calc_addr;
    logic walk_init;
    logic walk_run;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic item_report;
    logic walk_done;
  } dp_stat_t;

endpackage

/* hdl/tbr_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/tbr_datapath.sv */
// ----------------------------------------------------------------------------
// Table reader datapath
// Item register, address clamp, checksum walk and pass bookkeeping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tbr_datapath import tbr_pkg::*; #(
  parameter int NUM_FRAMES  = DEF_NUM_FRAMES,
  parameter int NUM_POINTS  = DEF_NUM_POINTS,
  parameter int NUM_WORDS   = DEF_NUM_WORDS,
  parameter int SLICE_WORDS = DEF_SLICE_WORDS,
  localparam int PW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1,
  localparam int SW = (SLICE_WORDS > 1) ? $clog2(SLICE_WORDS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  item_t             item,
  input  dp_cmd_t           dcmd,
  output dp_stat_t          stat,
  output logic              ram_we,
  output logic [PW-1:0]     ram_waddr,
  output logic [WORD_W-1:0] ram_wdata,
  output logic [PW-1:0]     ram_raddr,
  input  logic [WORD_W-1:0] ram_rdata,
  output result_t           result
);

  item_t              item_q;
  logic [PW-1:0]      rd_addr;
  logic               rd_ok;
  logic [WORD_W-1:0]  value_q;
  logic               val_pending;
  logic [PW-1:0]      sum_position;
  logic [WORD_W-1:0]  running_sum;
  logic [WORD_W-1:0]  held_sum;
  logic [PASS_W-1:0]  passes_done;
  logic [PW-1:0]      issue_pos;
  logic [SW-1:0]      issue_cnt;
  logic               issue_done;
  logic               acc_vld;
  logic               pass_end;
  logic [WORD_W-1:0]  h_work;
  logic [WORD_W-1:0]  h_next;
  logic               issue_last;
  logic [FRAME_W-1:0] frame_clamp;
  logic [POINT_W-1:0] point_clamp;
  logic [FLAT_W-1:0]  flat;
  logic [IDX_W-1:0]   wr_idx;
  logic               wr_ok;
  result_t            result_q;

  always_comb begin
    if ({1'b0, item_q.frame_sel} >= (FRAME_W + 1)'(NUM_FRAMES)) begin
      frame_clamp = FRAME_W'(NUM_FRAMES - 1);
    end else begin
      frame_clamp = item_q.frame_sel;
    end
    if ({1'b0, item_q.point_sel} >= (POINT_W + 1)'(NUM_POINTS)) begin
      point_clamp = POINT_W'(NUM_POINTS - 1);
    end else begin
      point_clamp = item_q.point_sel;
    end
    flat = FLAT_W'(frame_clamp) * FLAT_W'(NUM_POINTS) + FLAT_W'(point_clamp);
  end

  assign wr_idx    = IDX_W'(item_q.wr_addr);
  assign wr_ok     = wr_idx < IDX_W'(NUM_WORDS);
  assign ram_we    = dcmd.do_write && wr_ok;
  assign ram_waddr = wr_idx[PW-1:0];
  assign ram_wdata = item_q.wr_data;
  assign ram_raddr = dcmd.walk_init ? rd_addr : issue_pos;

  assign h_next     = WORD_W'(32'(h_work) * HASH_MULT) + ram_rdata;
  assign issue_last = (issue_cnt == SW'(SLICE_WORDS - 1)) ||
                      (issue_pos == PW'(NUM_WORDS - 1));

  assign stat.item_report = item.cmd;
  assign stat.walk_done   = issue_done && !acc_vld && !val_pending;

  always_ff @(posedge clk) begin
    if (dcmd.load_item) begin
      item_q <= item;
    end
    if (dcmd.calc_addr) begin
      rd_addr <= flat[PW-1:0];
      rd_ok   <= flat < FLAT_W'(NUM_WORDS);
    end
    if (dcmd.walk_init) begin
      issue_pos <= sum_position;
      issue_cnt <= '0;
      h_work    <= (sum_position == '0) ? '0 : running_sum;
    end
    if (dcmd.walk_run) begin
      if (val_pending) begin
        value_q <= rd_ok ? ram_rdata : '0;
      end
      if (acc_vld) begin
        h_work <= h_next;
      end
      if (!issue_done) begin
        issue_pos <= issue_pos + 1'b1;
        issue_cnt <= issue_cnt + 1'b1;
        pass_end  <= issue_pos == PW'(NUM_WORDS - 1);
      end
    end
    if (dcmd.commit) begin
      result_q.echo_frame  <= item_q.frame_sel;
      result_q.echo_point  <= item_q.point_sel;
      result_q.read_value  <= value_q;
      result_q.latched_sum <= pass_end ? h_work : held_sum;
      result_q.pass_count  <= pass_end ? passes_done + 1'b1 : passes_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      val_pending  <= 1'b0;
      issue_done   <= 1'b1;
      acc_vld      <= 1'b0;
      sum_position <= '0;
      running_sum  <= '0;
      held_sum     <= '0;
      passes_done  <= '0;
    end else begin
      if (dcmd.walk_init) begin
        val_pending <= 1'b1;
        issue_done  <= 1'b0;
        acc_vld     <= 1'b0;
      end
      if (dcmd.walk_run) begin
        val_pending <= 1'b0;
        acc_vld     <= !issue_done;
        if (!issue_done) begin
          issue_done <= issue_last;
        end
      end
      if (dcmd.commit) begin
        running_sum  <= h_work;
        sum_position <= pass_end ? '0 : issue_pos;
        if (pass_end) begin
          held_sum    <= h_work;
          passes_done <= passes_done + 1'b1;
        end
      end
    end
  end

  assign result = result_q;

  `ASSERT_SYNC(a_pass_state_holds, clk, rst, !dcmd.commit |=> $stable(held_sum) && $stable(passes_done), "pass state changed outside a commit")
  `ASSERT_NEVER(a_commit_mid_walk, clk, rst, dcmd.commit && (!issue_done || acc_vld), "commit before the slice walk drained")
  `ASSERT_SYNC(a_acc_from_walk, clk, rst, acc_vld |-> $past(dcmd.walk_run), "accumulate pending without a walk cycle")

endmodule

/* hdl/tbr_controller.sv */
// ----------------------------------------------------------------------------
// Table reader controller
// Sequences writes and reports and raises the result strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tbr_controller import tbr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output logic     done,
  input  dp_stat_t stat,
  output dp_cmd_t  dcmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_ADDR,
    S_READ,
    S_WALK,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (stat.item_report == CMD_REPORT) ? S_ADDR : S_WRITE;
        end
      end
      S_WRITE:  state_next = S_IDLE;
      S_ADDR:   state_next = S_READ;
      S_READ:   state_next = S_WALK;
      S_WALK: begin
        if (stat.walk_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= state == S_FINISH;
    end
  end

  assign busy           = state != S_IDLE;
  assign dcmd.load_item = (state == S_IDLE) && start;
  assign dcmd.do_write  = state == S_WRITE;
  assign dcmd.calc_addr = state == S_ADDR;
  assign dcmd.walk_init = state == S_READ;
  assign dcmd.walk_run  = state == S_WALK;
  assign dcmd.commit    = state == S_FINISH;

  `ASSERT_NEVER(a_done_while_busy, clk, rst, done && busy, "result strobe while busy")
  `ASSERT_SYNC(a_finish_strobes, clk, rst, (state == S_FINISH) |=> done, "finished report gave no strobe")
  `ASSERT_SYNC(a_accept_goes_busy, clk, rst, (start && !busy) |=> busy, "accepted transfer left controller idle")

endmodule

/* hdl/table_reader_with_background_checksum.sv */
// ----------------------------------------------------------------------------
// Table reader with background checksum
// A report walks a checksum slice through the single RAM read port before the
// done strobe. A new transfer is taken in the strobe cycle.
// Synchronous reset clears the checksum, pass count and control; no sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module table_reader_with_background_checksum import tbr_pkg::*; #(
  parameter int NUM_FRAMES  = DEF_NUM_FRAMES,
  parameter int NUM_POINTS  = DEF_NUM_POINTS,
  parameter int NUM_WORDS   = DEF_NUM_WORDS,
  parameter int SLICE_WORDS = DEF_SLICE_WORDS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  localparam int PW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  dp_cmd_t           dcmd;
  dp_stat_t          stat;
  logic              ram_we;
  logic [PW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [PW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  tbr_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .stat  (stat),
    .dcmd  (dcmd)
  );

  tbr_datapath #(
    .NUM_FRAMES  (NUM_FRAMES),
    .NUM_POINTS  (NUM_POINTS),
    .NUM_WORDS   (NUM_WORDS),
    .SLICE_WORDS (SLICE_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .dcmd      (dcmd),
    .stat      (stat),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .result    (result)
  );

  tbr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the table reader with background checksum
// The whole table is filled with write transfers first. A directed table of
// clamping and extreme cases follows, then a long stretch of random writes and
// reports, with random pauses by the sender. Each report is checked field by field
// against a typed row's own result or a predictor of the table and sliced checksum.
// ----------------------------------------------------------------------------

module testbench;
  import tbr_pkg::*;

  localparam int FRAMES = DEF_NUM_FRAMES;
  localparam int POINTS = DEF_NUM_POINTS;
  localparam int WORDS = DEF_NUM_WORDS;
  localparam int SLICE = DEF_SLICE_WORDS;
  localparam int RANDOM_ITEMS = 1100;
  localparam int DRAIN_CYCLES = DEF_SLICE_WORDS + 16;

  typedef struct packed {
    logic    typed;
    item_t   stim;
    result_t want;
  } row_t;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  logic    done;
  item_t   item;
  result_t result;

  logic [WORD_W-1:0] word_mem [0:WORDS-1];
  int unsigned       sum_pos;
  logic [WORD_W-1:0] run_sum;
  logic [WORD_W-1:0] held_sum;
  logic [PASS_W-1:0] passes;
  int                pass_total;

  result_t pending_results [$];
  row_t    directed_rows [$];
  int      errors;
  int      n_writes;
  int      n_reports;
  int      burst_left;

  table_reader_with_background_checksum dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic result_t predict_report(input item_t it);
    result_t     r;
    int unsigned cf;
    int unsigned cp;
    int unsigned flat;
    int unsigned stop;
    logic [WORD_W-1:0] h;
    cf = (it.frame_sel >= FRAMES) ? FRAMES - 1 : it.frame_sel;
    cp = (it.point_sel >= POINTS) ? POINTS - 1 : it.point_sel;
    flat = cf * POINTS + cp;
    r.echo_frame = it.frame_sel;
    r.echo_point = it.point_sel;
    r.read_value = (flat < WORDS) ? word_mem[flat] : '0;
    h = (sum_pos == 0) ? '0 : run_sum;
    stop = sum_pos + SLICE;
    if (stop > WORDS) stop = WORDS;
    for (int unsigned k = sum_pos; k < stop; k++) begin
      h = h * WORD_W'(HASH_MULT) + word_mem[k];
    end
    if (stop >= WORDS) begin
      held_sum = h;
      passes = passes + 1'b1;
      pass_total++;
      stop = 0;
    end
    sum_pos = stop;
    run_sum = h;
    r.latched_sum = held_sum;
    r.pass_count = passes;
    return r;
  endfunction

  function automatic item_t mk_item(input logic c, input int f, input int p, input int a,
                                    input int d);
    item_t it;
    it.cmd = c;
    it.frame_sel = f[FRAME_W-1:0];
    it.point_sel = p[POINT_W-1:0];
    it.wr_addr = a[WADDR_W-1:0];
    it.wr_data = d[WORD_W-1:0];
    return it;
  endfunction

  function automatic result_t mk_result(input int f, input int p, input int v, input int s,
                                        input int n);
    result_t r;
    r.echo_frame = f[FRAME_W-1:0];
    r.echo_point = p[POINT_W-1:0];
    r.read_value = v[WORD_W-1:0];
    r.latched_sum = s[WORD_W-1:0];
    r.pass_count = n[PASS_W-1:0];
    return r;
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.cmd = ($urandom_range(0, 99) < 35) ? CMD_WRITE : CMD_REPORT;
    case ($urandom_range(0, 3))
      0, 1: it.frame_sel = FRAME_W'($urandom_range(0, FRAMES - 1));
      2: it.frame_sel = FRAME_W'($urandom_range(0, 255));
      default: begin
        case ($urandom_range(0, 3))
          0: it.frame_sel = '0;
          1: it.frame_sel = FRAME_W'(FRAMES - 1);
          2: it.frame_sel = FRAME_W'(FRAMES);
          default: it.frame_sel = '1;
        endcase
      end
    endcase
    case ($urandom_range(0, 3))
      0, 1: it.point_sel = POINT_W'($urandom_range(0, POINTS - 1));
      2: it.point_sel = POINT_W'($urandom_range(0, 16383));
      default: begin
        case ($urandom_range(0, 3))
          0: it.point_sel = '0;
          1: it.point_sel = POINT_W'(POINTS - 1);
          2: it.point_sel = POINT_W'(POINTS);
          default: it.point_sel = '1;
        endcase
      end
    endcase
    it.wr_addr = WADDR_W'($urandom_range(0, WORDS - 1));
    it.wr_data = WORD_W'($urandom);
    return it;
  endfunction

  task automatic send_item(input item_t it, input logic typed, input result_t want);
    result_t predicted;
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (it.cmd == CMD_WRITE) begin
      word_mem[it.wr_addr] = it.wr_data;
      n_writes++;
    end else begin
      predicted = predict_report(it);
      pending_results.push_back(typed ? want : predicted);
      n_reports++;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(0, 8);
    end
  endtask

  task automatic field_mismatch(input string name, input int want, input int got);
    errors++;
    $error("%s mismatch: expected %0d, got %0d", name, want, got);
  endtask

  task automatic check_result(input result_t want, input result_t got);
    if (got.echo_frame !== want.echo_frame)
      field_mismatch("echo_frame", want.echo_frame, got.echo_frame);
    if (got.echo_point !== want.echo_point)
      field_mismatch("echo_point", want.echo_point, got.echo_point);
    if (got.read_value !== want.read_value)
      field_mismatch("read_value", want.read_value, got.read_value);
    if (got.latched_sum !== want.latched_sum)
      field_mismatch("latched_sum", want.latched_sum, got.latched_sum);
    if (got.pass_count !== want.pass_count)
      field_mismatch("pass_count", want.pass_count, got.pass_count);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        errors++;
        $error("result transfer with no report outstanding, echo_frame %0d",
               result.echo_frame);
      end else begin
        check_result(pending_results.pop_front(), result);
      end
    end
  end

  initial begin
    #12_000_000;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    item_t it;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    errors = 0;
    n_writes = 0;
    n_reports = 0;
    sum_pos = 0;
    run_sum = '0;
    held_sum = '0;
    passes = '0;
    pass_total = 0;
    burst_left = $urandom_range(0, 8);

    directed_rows.push_back('{1'b0, mk_item(CMD_WRITE, 255, 16383, 0, 32767), '0});
    directed_rows.push_back('{1'b0, mk_item(CMD_WRITE, 0, 0, 4095, -32768), '0});
    directed_rows.push_back('{1'b1, mk_item(CMD_REPORT, 0, 0, 4095, -1),
                              mk_result(0, 0, 32767, 0, 0)});
    directed_rows.push_back('{1'b1, mk_item(CMD_REPORT, 255, 16383, 0, 0),
                              mk_result(255, 16383, -32768, 0, 0)});
    directed_rows.push_back('{1'b1, mk_item(CMD_REPORT, 15, 255, 0, 0),
                              mk_result(15, 255, -32768, 0, 0)});
    directed_rows.push_back('{1'b1, mk_item(CMD_REPORT, 16, 256, 0, 0),
                              mk_result(16, 256, -32768, 0, 0)});
    directed_rows.push_back('{1'b0, mk_item(CMD_WRITE, 0, 0, 2048, 21845), '0});
    directed_rows.push_back('{1'b0, mk_item(CMD_WRITE, 0, 0, 2047, -21846), '0});
    directed_rows.push_back('{1'b1, mk_item(CMD_REPORT, 8, 0, 0, 0),
                              mk_result(8, 0, 21845, 0, 0)});
    directed_rows.push_back('{1'b1, mk_item(CMD_REPORT, 7, 255, 0, 0),
                              mk_result(7, 255, -21846, 0, 0)});
    directed_rows.push_back('{1'b0, mk_item(CMD_WRITE, 0, 0, 1, 0), '0});
    directed_rows.push_back('{1'b1, mk_item(CMD_REPORT, 0, 1, 0, 0),
                              mk_result(0, 1, 0, 0, 0)});
    directed_rows.push_back('{1'b0, mk_item(CMD_REPORT, 0, 16383, 0, 0), '0});
    directed_rows.push_back('{1'b0, mk_item(CMD_REPORT, 200, 1, 0, 0), '0});
    directed_rows.push_back('{1'b0, mk_item(CMD_REPORT, 15, 0, 0, 0), '0});
    directed_rows.push_back('{1'b0, mk_item(CMD_WRITE, 0, 0, 4095, -1), '0});
    directed_rows.push_back('{1'b1, mk_item(CMD_REPORT, 255, 255, 0, 0),
                              mk_result(255, 255, -1, 0, 0)});
    directed_rows.push_back('{1'b0, mk_item(CMD_WRITE, 0, 0, 255, 32767), '0});
    directed_rows.push_back('{1'b1, mk_item(CMD_REPORT, 0, 300, 0, 0),
                              mk_result(0, 300, 32767, 0, 0)});
    directed_rows.push_back('{1'b0, mk_item(CMD_REPORT, 1, 2, 4095, 32767), '0});

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Every word must hold a written value before the first report walks the table.
    for (int k = 0; k < WORDS; k++) begin
      it = random_item();
      it.cmd = CMD_WRITE;
      it.wr_addr = WADDR_W'(k);
      if (k % 512 == 3) it.wr_data = 16'sh8000;
      else if (k % 512 == 7) it.wr_data = 16'sh7fff;
      send_item(it, 1'b0, '0);
    end

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      send_item(random_item(), 1'b0, '0);
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d table write transfers and %0d report transfers, %0d checksum passes.",
             n_writes, n_reports, pass_total);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
